@@ hdl/sha1_pkg.sv @@
// Shared types, constants and helpers for the SHA-1 hash engine.
// Used by sha1_round and sha1_hash_engine; depends on nothing else.
package sha1_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS          = 80;
    localparam int DIGEST_WORDS    = 5;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_DIGEST_IDX = 3'(DIGEST_WORDS - 1);
    localparam logic [2:0] FULL_BYTES = 3'd4;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_0  = 32'h5A827999;
    localparam t_word K_20 = 32'h6ED9EBA1;
    localparam t_word K_40 = 32'h8F1BBCDC;
    localparam t_word K_60 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam t_word MARKER_WORD = {PAD_MARKER, 24'h0};

    // Keep the leading bytes of a partial final word and append the marker.
    function automatic t_word pad_partial(input t_word data, input logic [1:0] count);
        t_word r;
        case (count)
            2'd0:    r = {PAD_MARKER, 24'h0};
            2'd1:    r = {data[31:24], PAD_MARKER, 16'h0};
            2'd2:    r = {data[31:16], PAD_MARKER, 8'h0};
            2'd3:    r = {data[31:8], PAD_MARKER};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/sha1_round.sv @@
// One SHA-1 compression round: round function, constant and variable rotation.
// Depends on sha1_pkg.
module sha1_round (
    input  sha1_pkg::t_vars i_vars,
    input  sha1_pkg::t_word i_w,
    input  logic [6:0]      i_round,
    output sha1_pkg::t_vars o_vars
);
    import sha1_pkg::*;

    t_word f;
    t_word k;
    t_word sum;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_0;
        end else if (i_round < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_20;
        end else if (i_round < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_40;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_60;
        end
        sum = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + i_w;
        o_vars.a = sum;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

@@ hdl/sha1_hash_engine.sv @@
// SHA-1 hash engine top level: word buffer memory, padding, round sequencer, digest output.
// Depends on sha1_pkg and sha1_round.
//
// Message words enter one per cycle into a 16-word buffer memory until the block is full.
// Each block then passes through one memory prefetch, 80 rounds of the single round unit
// and one chaining update, during which input is stalled. After the final word the engine
// writes the padding and length words one per cycle, compresses one or two closing blocks,
// and then delivers the five digest words in order, one per cycle while the output is not
// stalled. The next message may begin while the last digest word still waits.
module sha1_hash_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sha1_pkg::t_word   i_data_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_last_of_message,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sha1_pkg::t_word   o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    t_word mem [WORDS_PER_BLOCK];

    logic [2:0]        r_state, n_state;
    logic [3:0]        r_fill, n_fill;
    logic [63:0]       r_len, n_len;
    logic              r_mark, n_mark;
    logic              r_pad, n_pad;
    logic              r_lenph, n_lenph;
    logic              r_final, n_final;
    logic [6:0]        r_round, n_round;
    logic [2:0]        r_oidx, n_oidx;
    logic [4:0][31:0]  r_h, n_h;
    t_vars             r_v, n_v;
    logic [15:0][31:0] r_w;
    t_word             r_rdata;
    logic              r_out_valid, n_out_valid;
    t_word             r_out_data;
    logic [2:0]        r_out_idx;
    logic              r_out_last;

    logic       in_acc;
    logic [2:0] eff_count;
    logic       mem_we;
    t_word      mem_wdata;
    logic [3:0] mem_raddr;
    t_word      w_cur;
    t_word      w_sched;
    t_vars      round_out;
    logic       out_load;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign eff_count     = (!i_last_of_message || i_byte_count > FULL_BYTES) ?
                           FULL_BYTES : i_byte_count;
    assign w_sched       = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_cur         = (r_round < 7'(WORDS_PER_BLOCK)) ? r_rdata :
                           {w_sched[30:0], w_sched[31]};
    assign mem_raddr     = (r_state == ST_PREP) ? 4'd0 : r_round[3:0] + 4'd1;
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_data;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

    sha1_round u_round (
        .i_vars  (r_v),
        .i_w     (w_cur),
        .i_round (r_round),
        .o_vars  (round_out)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_mark      = r_mark;
        n_pad       = r_pad;
        n_lenph     = r_lenph;
        n_final     = r_final;
        n_round     = r_round;
        n_oidx      = r_oidx;
        n_h         = r_h;
        n_v         = r_v;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wdata   = i_data_word;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    mem_we = 1'b1;
                    n_fill = r_fill + 4'd1;
                    n_len  = r_len + {58'd0, eff_count, 3'd0};
                    if (i_last_of_message) begin
                        n_pad = 1'b1;
                        if (eff_count == FULL_BYTES) begin
                            n_mark = 1'b1;
                        end else begin
                            mem_wdata = pad_partial(i_data_word, eff_count[1:0]);
                        end
                    end
                    if (r_fill == 4'(WORDS_PER_BLOCK - 1)) begin
                        n_state = ST_PREP;
                    end else if (i_last_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                mem_we = 1'b1;
                n_fill = r_fill + 4'd1;
                if (r_mark) begin
                    mem_wdata = MARKER_WORD;
                    n_mark    = 1'b0;
                end else if (r_fill == 4'(WORDS_PER_BLOCK - 2)) begin
                    mem_wdata = r_len[63:32];
                    n_lenph   = 1'b1;
                end else if (r_fill == 4'(WORDS_PER_BLOCK - 1) && r_lenph) begin
                    mem_wdata = r_len[31:0];
                    n_final   = 1'b1;
                end else begin
                    mem_wdata = '0;
                end
                if (r_fill == 4'(WORDS_PER_BLOCK - 1)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_v.a   = r_h[0];
                n_v.b   = r_h[1];
                n_v.c   = r_h[2];
                n_v.d   = r_h[3];
                n_v.e   = r_h[4];
                n_round = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_v     = round_out;
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_h[0] = r_h[0] + r_v.a;
                n_h[1] = r_h[1] + r_v.b;
                n_h[2] = r_h[2] + r_v.c;
                n_h[3] = r_h[3] + r_v.d;
                n_h[4] = r_h[4] + r_v.e;
                if (r_final) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_oidx      = r_oidx + 3'd1;
                    if (r_oidx == LAST_DIGEST_IDX) begin
                        n_h     = H_INIT;
                        n_len   = '0;
                        n_pad   = 1'b0;
                        n_lenph = 1'b0;
                        n_final = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_mark      <= 1'b0;
            r_pad       <= 1'b0;
            r_lenph     <= 1'b0;
            r_final     <= 1'b0;
            r_round     <= '0;
            r_oidx      <= '0;
            r_h         <= H_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_mark      <= n_mark;
            r_pad       <= n_pad;
            r_lenph     <= n_lenph;
            r_final     <= n_final;
            r_round     <= n_round;
            r_oidx      <= n_oidx;
            r_h         <= n_h;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        if (r_state == ST_ROUND) begin
            r_w <= {w_cur, r_w[15:1]};
        end
        if (out_load) begin
            r_out_data <= r_h[r_oidx];
            r_out_idx  <= r_oidx;
            r_out_last <= (r_oidx == LAST_DIGEST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    a_round_after_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && $past(r_state) != ST_ROUND) |-> $past(r_state) == ST_PREP)
        else $error("rounds started without memory prefetch");

    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |-> ($past(r_state) == ST_ROUND && $past(r_round) == LAST_ROUND))
        else $error("chaining update before all rounds done");

    a_out_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fill == 4'd0 && !r_mark && r_final))
        else $error("digest output with block buffer not drained");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word) |-> o_word_index == LAST_DIGEST_IDX)
        else $error("last digest word flagged at wrong index");

    a_idle_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_oidx == LAST_DIGEST_IDX) |=> (r_state == ST_IDLE && r_len == 64'd0))
        else $error("engine not returned to start after digest");

endmodule

@@ tb/sha1_digest_board_pkg.sv @@
`timescale 1ns / 1ps
// Digest scoreboard for the SHA-1 hash engine: a bit-true predictor of the digest
// of each message and an in-order check of the digest words. Depends on sha1_pkg.
package sha1_digest_board_pkg;

    import sha1_pkg::t_word;

    localparam t_word IV_A = 32'h67452301;
    localparam t_word IV_B = 32'hEFCDAB89;
    localparam t_word IV_C = 32'h98BADCFE;
    localparam t_word IV_D = 32'h10325476;
    localparam t_word IV_E = 32'hC3D2E1F0;

    localparam t_word RK_0  = 32'h5A827999;
    localparam t_word RK_20 = 32'h6ED9EBA1;
    localparam t_word RK_40 = 32'h8F1BBCDC;
    localparam t_word RK_60 = 32'hCA62C1D6;

    localparam t_word       PAD_WORD   = 32'h8000_0000;
    localparam logic [2:0]  FULL_WORD  = 3'd4;
    localparam int unsigned LEN_SLOT   = 14;
    localparam int unsigned BLOCK_SIZE = 16;
    localparam int unsigned MAX_REPORT = 10;

    typedef struct {
        t_word      value;
        logic [2:0] index;
        logic       last;
    } t_digest_word;

    class sha1_digest_board;
        t_word        hash_state[5];
        t_word        block_words[16];
        int unsigned  block_fill;
        logic [63:0]  msg_bits;
        t_digest_word expected_digest[$];
        int unsigned  failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            hash_state[0] = IV_A;
            hash_state[1] = IV_B;
            hash_state[2] = IV_C;
            hash_state[3] = IV_D;
            hash_state[4] = IV_E;
            block_fill = 0;
            msg_bits = '0;
        endfunction

        function t_word rotl(t_word x, int unsigned n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            t_word v[5];
            t_word w[16];
            t_word f, k, sched, sum;
            w = block_words;
            for (int i = 0; i < 5; i++) v[i] = hash_state[i];
            for (int t = 0; t < 80; t++) begin
                if (t >= 16) begin
                    sched = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^
                                 w[(t - 14) & 15] ^ w[t & 15], 1);
                    w[t & 15] = sched;
                end else begin
                    sched = w[t];
                end
                if (t < 20) begin
                    f = (v[1] & v[2]) | (~v[1] & v[3]);
                    k = RK_0;
                end else if (t < 40) begin
                    f = v[1] ^ v[2] ^ v[3];
                    k = RK_20;
                end else if (t < 60) begin
                    f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
                    k = RK_40;
                end else begin
                    f = v[1] ^ v[2] ^ v[3];
                    k = RK_60;
                end
                sum = rotl(v[0], 5) + f + v[4] + k + sched;
                v[4] = v[3];
                v[3] = v[2];
                v[2] = rotl(v[1], 30);
                v[1] = v[0];
                v[0] = sum;
            end
            for (int i = 0; i < 5; i++) hash_state[i] += v[i];
            block_fill = 0;
        endfunction

        function void absorb(t_word w);
            block_words[block_fill] = w;
            block_fill++;
            if (block_fill == BLOCK_SIZE) compress();
        endfunction

        function void note_word(t_word data, logic [2:0] count, logic last);
            int unsigned  nbytes;
            t_word        keep;
            t_digest_word d;
            nbytes = (count > FULL_WORD || !last) ? 4 : count;
            msg_bits += 64'(nbytes * 8);
            if (!last) begin
                absorb(data);
            end else begin
                if (nbytes == 4) begin
                    absorb(data);
                    absorb(PAD_WORD);
                end else begin
                    keep = '1;
                    keep = (nbytes == 0) ? '0 : keep << (32 - 8 * nbytes);
                    absorb((data & keep) | (PAD_WORD >> (8 * nbytes)));
                end
                while (block_fill != LEN_SLOT) absorb('0);
                absorb(msg_bits[63:32]);
                absorb(msg_bits[31:0]);
                for (int i = 0; i < 5; i++) begin
                    d.value = hash_state[i];
                    d.index = 3'(i);
                    d.last  = (i == 4);
                    expected_digest.push_back(d);
                end
                restart();
            end
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORT) $display("%s", msg);
        endfunction

        function void check_digest(t_word value, logic [2:0] index, logic last);
            t_digest_word d;
            if (expected_digest.size() == 0) begin
                note_failure($sformatf("ERROR: unexpected digest word %h index %0d last %0b",
                                       value, index, last));
            end else begin
                d = expected_digest.pop_front();
                if (value !== d.value || index !== d.index || last !== d.last)
                    note_failure($sformatf(
                        "ERROR: digest word exp %h/%0d/%0b got %h/%0d/%0b",
                        d.value, d.index, d.last, value, index, last));
            end
        endfunction

        function int pending();
            return expected_digest.size();
        endfunction
    endclass

endpackage

@@ tb/tb_sha1_hash_engine.sv @@
`timescale 1ns / 1ps
// Top-level testbench for sha1_hash_engine: directed and random messages, random idling
// on both sides and one long output hold-off. Depends on sha1_pkg and sha1_digest_board_pkg.
module tb_sha1_hash_engine;

    import sha1_pkg::t_word;
    import sha1_digest_board_pkg::*;

    localparam int          CLK_PERIOD     = 12;
    localparam int unsigned RANDOM_WORDS   = 180;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned DRAIN_LIMIT    = 20_000;
    localparam int unsigned SETTLE_CYCLES  = 250;
    localparam int unsigned TIMEOUT_CYCLES = 400_000;
    localparam int unsigned MAX_GAP        = 17;

    logic       clk;
    logic       rst_n;
    logic       word_valid;
    logic       word_stall;
    t_word      data_word;
    logic [2:0] byte_count;
    logic       last_of_message;
    logic       digest_valid;
    logic       digest_stall;
    t_word      digest_word;
    logic [2:0] word_index;
    logic       last_word;

    sha1_digest_board board;
    bit          send_calm;
    bit          recv_calm;
    bit          hold_armed;
    bit          hold_done;
    int unsigned words_sent;

    sha1_hash_engine u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (word_valid),
        .o_in_stall        (word_stall),
        .i_data_word       (data_word),
        .i_byte_count      (byte_count),
        .i_last_of_message (last_of_message),
        .o_out_valid       (digest_valid),
        .i_out_stall       (digest_stall),
        .o_digest_word     (digest_word),
        .o_word_index      (word_index),
        .o_last_word       (last_word)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic draw_gap(inout bit calm, output int unsigned gap);
        if ($urandom_range(0, 15) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    endtask

    task automatic send_word(input t_word data, input logic [2:0] count, input logic last);
        int unsigned gap;
        draw_gap(send_calm, gap);
        if (gap > 0) begin
            word_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_valid      <= 1'b1;
        data_word       <= data;
        byte_count      <= count;
        last_of_message <= last;
        do @(posedge clk); while (word_stall);
        board.note_word(data, count, last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int unsigned body_words, input bit noisy);
        logic [2:0] count;
        for (int unsigned i = 0; i < body_words; i++) begin
            count = noisy ? 3'($urandom_range(0, 7)) : FULL_WORD;
            send_word($urandom, count, 1'b0);
        end
        count = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
        send_word($urandom, count, 1'b1);
    endtask

    initial begin
        digest_stall <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin : drain_digest
            int unsigned gap;
            draw_gap(recv_calm, gap);
            if (hold_armed && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                digest_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            digest_stall <= 1'b0;
            do @(posedge clk); while (!digest_valid);
            board.check_digest(digest_word, word_index, last_word);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int unsigned waited;
        board           = new();
        words_sent      = 0;
        rst_n           <= 1'b0;
        word_valid      <= 1'b0;
        data_word       <= '0;
        byte_count      <= '0;
        last_of_message <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message, partial final words, oversize counts, junk past the count
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'h6162_6364, 3'd2, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
        send_word(32'h0000_0000, 3'd6, 1'b1);
        send_word(32'hA5A5_5A5A, 3'd7, 1'b1);
        // short count on a body word, then an empty final word
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word(32'hDEAD_BEEF, 3'd0, 1'b1);
        // 55 bytes: length fits in the same block
        for (int i = 0; i < 13; i++) send_word($urandom, FULL_WORD, 1'b0);
        send_word($urandom, 3'd3, 1'b1);

        hold_armed = 1'b1;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(16, 40), $urandom_range(0, 7) == 0);
            else
                send_message($urandom_range(0, 17), $urandom_range(0, 7) == 0);
        end
        word_valid <= 1'b0;

        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sha1_hash_engine.f @@
hdl/sha1_pkg.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine.sv
tb/sha1_digest_board_pkg.sv
tb/tb_sha1_hash_engine.sv
